>>> sv/zolh_pkg.sv
// Shared types, codes and defaults for the z-ordered layer hit table.
package zolh_pkg;

   // Default sizes of the table and the edge format.
   localparam int MAX_LAYERS_DEF     = 16;
   localparam int EDGE_FRAC_BITS_DEF = 4;
   localparam int EDGE_W             = 20;
   localparam int POINT_W            = 16;

   // Operation codes of an input word.
   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_HIT    = 2'd1;
   localparam logic [1:0] OP_FRONT  = 2'd2;
   localparam logic [1:0] OP_REMOVE = 2'd3;

   // Status codes of a result word.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   // One rectangle as held in the table.
   typedef struct packed {
      logic signed [EDGE_W-1:0] left;
      logic signed [EDGE_W-1:0] top;
      logic signed [EDGE_W-1:0] right;
      logic signed [EDGE_W-1:0] bottom;
   } rect_type;

   // Fields of one result word.
   typedef struct packed {
      logic [1:0] status;
      logic       hit_found;
      logic [3:0] hit_index;
      logic       active_valid;
      logic [3:0] active_layer;
      logic [4:0] layer_count;
   } rsp_type;

endpackage

>>> sv/z_ordered_layer_hit_table.sv
// Top level of the z-ordered layer hit table.
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   op, index, point, rectangle edges
//   rsp_      out        rsp_valid/rsp_stall   status, hit, active layer, count
//
// Append and any bad index pass from the execute state straight to the finish state.
// Hit test scans the layers from the top down until a hit or the bottom.
// Bring to front and remove shift every entry above the index down by one place.
// Scans and shifts go through the store's single read port, one entry per cycle.
// Reset is synchronous and empties the table; no clearing pass is needed.
// A held result does not block the next word, which then waits until it is taken.
module z_ordered_layer_hit_table import zolh_pkg::*; #(
   parameter int MAX_LAYERS     = MAX_LAYERS_DEF,
   parameter int EDGE_FRAC_BITS = EDGE_FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_op,
   input  logic [3:0]                req_index,
   input  logic signed [POINT_W-1:0] req_point_x,
   input  logic signed [POINT_W-1:0] req_point_y,
   input  logic signed [EDGE_W-1:0]  req_edge_left,
   input  logic signed [EDGE_W-1:0]  req_edge_top,
   input  logic signed [EDGE_W-1:0]  req_edge_right,
   input  logic signed [EDGE_W-1:0]  req_edge_bottom,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic                      rsp_hit_found,
   output logic [3:0]                rsp_hit_index,
   output logic                      rsp_active_valid,
   output logic [3:0]                rsp_active_layer,
   output logic [4:0]                rsp_layer_count
);

   localparam int AW = $clog2(MAX_LAYERS);
   localparam int CW = $clog2(MAX_LAYERS + 1);
   localparam int PW = POINT_W + EDGE_FRAC_BITS;

   logic                 idle, done, accept, out_free, contains;
   logic [1:0]           op_ff;
   logic [3:0]           index_ff;
   logic signed [PW-1:0] px_ff, py_ff;
   rect_type             rect_ff, rd_data, wr_data;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic                 wr_en;
   rsp_type              result, rsp_ff;
   logic                 rsp_valid_ff;

   assign req_stall = !idle;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Capture of the accepted word; the point is scaled to the edge format here.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff          <= req_op;
         index_ff       <= req_index;
         px_ff          <= PW'(req_point_x) <<< EDGE_FRAC_BITS;
         py_ff          <= PW'(req_point_y) <<< EDGE_FRAC_BITS;
         rect_ff.left   <= req_edge_left;
         rect_ff.top    <= req_edge_top;
         rect_ff.right  <= req_edge_right;
         rect_ff.bottom <= req_edge_bottom;
      end
   end

   zolh_mem #(
      .DEPTH (MAX_LAYERS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   zolh_hit #(
      .EDGE_FRAC_BITS (EDGE_FRAC_BITS)
   ) u_hit (
      .px       (px_ff),
      .py       (py_ff),
      .rect     (rd_data),
      .contains (contains)
   );

   zolh_ctrl #(
      .MAX_LAYERS (MAX_LAYERS),
      .AW         (AW),
      .CW         (CW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .out_free (out_free),
      .op       (op_ff),
      .index    (index_ff),
      .rect     (rect_ff),
      .rd_data  (rd_data),
      .contains (contains),
      .idle     (idle),
      .done     (done),
      .result   (result),
      .rd_addr  (rd_addr),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   // Output register: holds one result word until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_hit_found    = rsp_ff.hit_found;
   assign rsp_hit_index    = rsp_ff.hit_index;
   assign rsp_active_valid = rsp_ff.active_valid;
   assign rsp_active_layer = rsp_ff.active_layer;
   assign rsp_layer_count  = rsp_ff.layer_count;

endmodule

>>> sv/zolh_mem.sv
// Rectangle store: one write port, one read port with registered read data.
module zolh_mem import zolh_pkg::*; #(
   parameter int DEPTH = MAX_LAYERS_DEF,
   parameter int AW    = $clog2(MAX_LAYERS_DEF)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  rect_type      wr_data,
   input  logic [AW-1:0] rd_addr,
   output rect_type      rd_data
);

   rect_type mem_ff [DEPTH];
   rect_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, with registered read data.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/zolh_hit.sv
// Closed-rectangle containment test of a scaled point against one stored entry.
module zolh_hit import zolh_pkg::*; #(
   parameter int EDGE_FRAC_BITS = EDGE_FRAC_BITS_DEF
) (
   input  logic signed [POINT_W+EDGE_FRAC_BITS-1:0] px,
   input  logic signed [POINT_W+EDGE_FRAC_BITS-1:0] py,
   input  rect_type                                 rect,
   output logic                                     contains
);

   localparam int PW  = POINT_W + EDGE_FRAC_BITS;
   localparam int CPW = (PW > EDGE_W) ? PW : EDGE_W;

   logic signed [CPW-1:0] x_c, y_c, l_c, t_c, r_c, b_c;

   // Bring everything to a common signed width, then compare every edge.
   always_comb begin
      x_c      = CPW'(px);
      y_c      = CPW'(py);
      l_c      = CPW'(rect.left);
      t_c      = CPW'(rect.top);
      r_c      = CPW'(rect.right);
      b_c      = CPW'(rect.bottom);
      contains = (x_c >= l_c) && (x_c <= r_c) && (y_c >= t_c) && (y_c <= b_c);
   end

endmodule

>>> sv/zolh_ctrl.sv
// Sequencer: decodes a word, scans or shifts the rectangle store, keeps the counters.
module zolh_ctrl import zolh_pkg::*; #(
   parameter int MAX_LAYERS = MAX_LAYERS_DEF,
   parameter int AW         = $clog2(MAX_LAYERS_DEF),
   parameter int CW         = $clog2(MAX_LAYERS_DEF + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          out_free,
   input  logic [1:0]    op,
   input  logic [3:0]    index,
   input  rect_type      rect,
   input  rect_type      rd_data,
   input  logic          contains,
   output logic          idle,
   output logic          done,
   output rsp_type       result,
   output logic [AW-1:0] rd_addr,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output rect_type      wr_data
);

   localparam int XW = CW + 4;

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_SCAN, S_MOVE, S_PLACE, S_FIN
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             act_ff, act_in;
   logic [AW-1:0]    pos_ff, pos_in;
   logic [1:0]       status_ff, status_in;
   logic             found_ff, found_in;
   logic [AW-1:0]    hit_ff, hit_in;
   logic [CW-1:0]    ptr_ff, ptr_in;
   logic [CW-1:0]    left_ff, left_in;
   logic             iss_ff, iss_in;
   logic [AW-1:0]    iss_addr_ff, iss_addr_in;
   rect_type         saved_ff, saved_in;

   logic [XW-1:0]    idx_x, cnt_x, hit_x, pos_x;
   logic [AW-1:0]    idx_a;
   logic             issue;

   // Widened views for range checks and for the fixed-width result fields.
   always_comb begin
      idx_x = XW'(index);
      cnt_x = XW'(count_ff);
      hit_x = XW'(hit_ff);
      pos_x = XW'(pos_ff);
      idx_a = idx_x[AW-1:0];
   end

   // Next-state logic. The store is never read in the cycle that writes the same
   // entry: shifting reads two entries above the one it writes, the final placement
   // comes after the last read.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      act_in      = act_ff;
      pos_in      = pos_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      hit_in      = hit_ff;
      ptr_in      = ptr_ff;
      left_in     = left_ff;
      iss_in      = 1'b0;
      iss_addr_in = ptr_ff[AW-1:0];
      saved_in    = saved_ff;
      rd_addr     = ptr_ff[AW-1:0];
      wr_en       = 1'b0;
      wr_addr     = iss_addr_ff - 1'b1;
      wr_data     = rd_data;
      issue       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            status_in = ST_OK;
            found_in  = 1'b0;
            hit_in    = '0;
            case (op)
               OP_APPEND: begin
                  if (count_ff == CW'(MAX_LAYERS)) begin
                     status_in = ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[AW-1:0];
                     wr_data  = rect;
                     count_in = count_ff + 1'b1;
                  end
                  state_in = S_FIN;
               end
               OP_HIT: begin
                  ptr_in   = count_ff - 1'b1;
                  left_in  = count_ff;
                  state_in = S_SCAN;
               end
               default: begin
                  if (idx_x >= cnt_x) begin
                     status_in = ST_BAD_INDEX;
                     state_in  = S_FIN;
                  end else begin
                     ptr_in   = (op == OP_FRONT) ? idx_x[CW-1:0] : idx_x[CW-1:0] + 1'b1;
                     state_in = S_MOVE;
                  end
               end
            endcase
         end

         // Top-down scan: one read issued per cycle, compared in the next cycle.
         S_SCAN: begin
            if (iss_ff && contains) begin
               found_in = 1'b1;
               hit_in   = iss_addr_ff;
               state_in = S_FIN;
            end else if (left_ff == '0) begin
               state_in = S_FIN;
            end else begin
               issue       = 1'b1;
               iss_in      = 1'b1;
               iss_addr_in = ptr_ff[AW-1:0];
               ptr_in      = ptr_ff - 1'b1;
               left_in     = left_ff - 1'b1;
            end
         end

         // Shift entries above the index down by one place; bring to front first saves the indexed entry.
         S_MOVE: begin
            issue = (ptr_ff < count_ff);
            if (issue) begin
               iss_in      = 1'b1;
               iss_addr_in = ptr_ff[AW-1:0];
               ptr_in      = ptr_ff + 1'b1;
            end
            if (iss_ff) begin
               if ((op == OP_FRONT) && (iss_addr_ff == idx_a)) begin
                  saved_in = rd_data;
               end else begin
                  wr_en = 1'b1;
               end
            end
            if (!issue && !iss_ff) begin
               if (op == OP_FRONT) begin
                  state_in = S_PLACE;
               end else begin
                  count_in = count_ff - 1'b1;
                  state_in = S_FIN;
                  if ((count_ff == CW'(1)) || (act_ff && (pos_ff == idx_a))) begin
                     act_in = 1'b0;
                     pos_in = '0;
                  end else if (act_ff && (pos_ff > idx_a)) begin
                     pos_in = pos_ff - 1'b1;
                  end
               end
            end
         end

         // The brought-forward entry goes on top and becomes active.
         S_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = count_ff[AW-1:0] - 1'b1;
            wr_data  = saved_ff;
            act_in   = 1'b1;
            pos_in   = count_ff[AW-1:0] - 1'b1;
            state_in = S_FIN;
         end

         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         act_ff    <= 1'b0;
         pos_ff    <= '0;
         iss_ff    <= 1'b0;
         status_ff <= ST_OK;
         found_ff  <= 1'b0;
         hit_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         act_ff    <= act_in;
         pos_ff    <= pos_in;
         iss_ff    <= iss_in;
         status_ff <= status_in;
         found_ff  <= found_in;
         hit_ff    <= hit_in;
      end
      ptr_ff      <= ptr_in;
      left_ff     <= left_in;
      iss_addr_ff <= iss_addr_in;
      saved_ff    <= saved_in;
   end

   // Result word from the held state.
   always_comb begin
      idle                = (state_ff == S_IDLE);
      done                = (state_ff == S_FIN) && out_free;
      result.status       = status_ff;
      result.hit_found    = found_ff;
      result.hit_index    = hit_x[3:0];
      result.active_valid = act_ff;
      result.active_layer = act_ff ? pos_x[3:0] : 4'd0;
      result.layer_count  = cnt_x[4:0];
   end

endmodule

>>> sv/zolh_chk.sv
// Port-level checks of the layer hit table, bound to the top level.
module zolh_chk import zolh_pkg::*; #(
   parameter int MAX_LAYERS = MAX_LAYERS_DEF
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [1:0]                rsp_status,
   input logic                      rsp_hit_found,
   input logic [3:0]                rsp_hit_index,
   input logic                      rsp_active_valid,
   input logic [3:0]                rsp_active_layer,
   input logic [4:0]                rsp_layer_count
);

   // A stalled result word stays and keeps its status, active layer and layer count.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_layer_count)
         && $stable(rsp_status) && $stable(rsp_active_layer))
      else $error("stalled result word changed");

   // A miss reports index zero.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit_found |-> rsp_hit_index == 4'd0)
      else $error("hit index set without a hit");

   // Errors never come with a hit.
   a_err_nohit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> !rsp_hit_found)
      else $error("hit reported with an error status");

   // The active layer and any hit lie inside the table.
   a_active_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_active_valid && (MAX_LAYERS <= 16)
         |-> (5'(rsp_active_layer) < rsp_layer_count))
      else $error("active layer beyond layer count");

   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_found && (MAX_LAYERS <= 16)
         |-> (5'(rsp_hit_index) < rsp_layer_count))
      else $error("hit index beyond layer count");

endmodule

bind z_ordered_layer_hit_table zolh_chk #(.MAX_LAYERS(MAX_LAYERS)) u_zolh_chk (.*);
